// ===== hw/rtl/cpa_pkg.sv =====
// ----------------------------------------------------------------------------
// cpa_pkg
// Shared types and constants of the contiguous page allocator.
// ----------------------------------------------------------------------------
package cpa_pkg;

    localparam int CNT_W   = 11;
    localparam int FRAME_W = 20;

    localparam logic [CNT_W-1:0]   POOL_RESET = 11'd1024;
    localparam logic [FRAME_W-1:0] BASE_RESET = 20'd0;

    localparam logic CFG_POOL_PAGES = 1'b0;
    localparam logic CFG_BASE_FRAME = 1'b1;

    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE  = 1'b1;

    typedef struct packed {
        logic used;
        logic linked;
    } page_t;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_SCAN = 5'b00010,
        ST_MARK = 5'b00100,
        ST_WALK = 5'b01000,
        ST_DONE = 5'b10000
    } state_t;

endpackage

// ===== hw/rtl/cpa_cell.sv =====
// ----------------------------------------------------------------------------
// cpa_cell
// One page entry of the rotating page ring: used and link bits.
// ----------------------------------------------------------------------------
module cpa_cell
    import cpa_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  shift,
    input  page_t d,
    output page_t q
);

    page_t page_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            page_reg <= '0;
        end
        else if (shift)
        begin
            page_reg <= d;
        end
    end

    assign q = page_reg;

endmodule

// ===== hw/rtl/contiguous_page_allocator_unit.sv =====
// ----------------------------------------------------------------------------
// contiguous_page_allocator_unit
// First-fit contiguous page allocator over a ring of page cells.
//
// channel  dir  handshake          content
// s_axis   in   tvalid/tready      tdata: page_count, free_frame; tuser: mode
// m_axis   out  tvalid/tready      tdata: ok, run_frame, released
// cfg      in   cfg_we             cfg_index, cfg_data
//
// the page ring rotates one page per cycle past a single head position while a pass runs
// allocate: a search pass over the whole ring, plus a marking pass over the
// whole ring when a run fits; free: one walk pass over the whole ring
// zero count or out-of-pool free: no pass, straight to the done state, then the result
// reset clears all page bits at once, no clearing pass
// one item at a time; a finished result waits in the output register
// ----------------------------------------------------------------------------
module contiguous_page_allocator_unit
    import cpa_pkg::*;
#(
    parameter int MAX_PAGES = 1024
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // page_count[10:0], free_frame[30:11], zero
    input  logic        s_tuser,   // mode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // ok[0], run_frame[20:1], released[31:21]
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [19:0] cfg_data
);

    localparam int IW = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
    localparam int SW = $clog2(MAX_PAGES + 1);
    localparam logic [IW-1:0] LAST = IW'(MAX_PAGES - 1);

    logic [CNT_W-1:0]   pool_pages_reg;
    logic [FRAME_W-1:0] base_frame_reg;

    state_t state_reg, state_next;
    logic [IW-1:0] p_reg, p_next;
    logic [SW-1:0] run_reg, run_next;
    logic [SW-1:0] count_reg, count_next;
    logic [IW-1:0] first_reg, first_next;
    logic [IW-1:0] last_reg, last_next;
    logic [IW-1:0] page_reg, page_next;
    logic [CNT_W-1:0] want_reg, want_next;
    logic found_reg, found_next;
    logic walk_reg, walk_next;

    logic res_ok_reg, res_ok_next;
    logic [FRAME_W-1:0] res_frame_reg, res_frame_next;
    logic [CNT_W-1:0] res_rel_reg, res_rel_next;
    logic out_valid_reg, out_valid_next;
    logic [31:0] out_data_reg, out_data_next;

    logic [SW-1:0] n_pages;
    logic shift;
    page_t head, tail;
    page_t ring_q [MAX_PAGES];
    page_t ring_d [MAX_PAGES];
    logic [FRAME_W-1:0] free_page;
    logic [SW-1:0] run_inc;

    always_comb
    begin
        if (32'(pool_pages_reg) > 32'(MAX_PAGES))
        begin
            n_pages = SW'(MAX_PAGES);
        end
        else
        begin
            n_pages = SW'(pool_pages_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pool_pages_reg <= POOL_RESET;
            base_frame_reg <= BASE_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_POOL_PAGES: pool_pages_reg <= cfg_data[CNT_W-1:0];
                CFG_BASE_FRAME: base_frame_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign shift = (state_reg == ST_SCAN) || (state_reg == ST_MARK) ||
                   (state_reg == ST_WALK);
    assign head  = ring_q[0];

    genvar gi;
    generate
        for (gi = 0; gi < MAX_PAGES; gi++)
        begin : g_ring
            if (gi == MAX_PAGES - 1)
            begin : g_tail
                assign ring_d[gi] = tail;
            end
            else
            begin : g_mid
                assign ring_d[gi] = ring_q[gi+1];
            end
            cpa_cell u_cell (
                .clk   (clk),
                .rst_n (rst_n),
                .shift (shift),
                .d     (ring_d[gi]),
                .q     (ring_q[gi])
            );
        end
    endgenerate

    assign free_page = s_tdata[30:11] - base_frame_reg;
    assign run_inc   = run_reg + SW'(1);

    always_comb
    begin
        state_next     = state_reg;
        p_next         = p_reg;
        run_next       = run_reg;
        count_next     = count_reg;
        first_next     = first_reg;
        last_next      = last_reg;
        page_next      = page_reg;
        want_next      = want_reg;
        found_next     = found_reg;
        walk_next      = walk_reg;
        res_ok_next    = res_ok_reg;
        res_frame_next = res_frame_reg;
        res_rel_next   = res_rel_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        tail           = head;

        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    p_next         = '0;
                    run_next       = '0;
                    count_next     = '0;
                    found_next     = 1'b0;
                    walk_next      = 1'b0;
                    want_next      = s_tdata[10:0];
                    page_next      = IW'(free_page);
                    res_ok_next    = 1'b0;
                    res_frame_next = '0;
                    res_rel_next   = '0;
                    if (s_tuser == MODE_ALLOC)
                    begin
                        state_next = (s_tdata[10:0] == '0) ? ST_DONE : ST_SCAN;
                    end
                    else
                    begin
                        state_next = (32'(free_page) < 32'(n_pages)) ? ST_WALK : ST_DONE;
                    end
                end
            end
            ST_SCAN:
            begin
                if (32'(p_reg) < 32'(n_pages) && !found_reg)
                begin
                    if (head.used)
                    begin
                        run_next = '0;
                    end
                    else
                    begin
                        run_next = run_inc;
                        if (32'(run_inc) == 32'(want_reg))
                        begin
                            found_next = 1'b1;
                            first_next = IW'(32'(p_reg) + 32'd1 - 32'(want_reg));
                            last_next  = p_reg;
                        end
                    end
                end
                p_next = p_reg + IW'(1);
                if (p_reg == LAST)
                begin
                    p_next     = '0;
                    state_next = found_next ? ST_MARK : ST_DONE;
                end
            end
            ST_MARK:
            begin
                if (p_reg >= first_reg && p_reg <= last_reg)
                begin
                    tail.used   = 1'b1;
                    tail.linked = (p_reg != last_reg);
                end
                p_next = p_reg + IW'(1);
                if (p_reg == LAST)
                begin
                    p_next         = '0;
                    state_next     = ST_DONE;
                    res_ok_next    = 1'b1;
                    res_frame_next = FRAME_W'(32'(base_frame_reg) + 32'(first_reg));
                end
            end
            ST_WALK:
            begin
                if (p_reg == page_reg || walk_reg)
                begin
                    tail.used  = 1'b0;
                    count_next = count_reg + SW'(1);
                    walk_next  = head.linked && (32'(p_reg) + 32'd1 < 32'(n_pages));
                end
                p_next = p_reg + IW'(1);
                if (p_reg == LAST)
                begin
                    p_next       = '0;
                    state_next   = ST_DONE;
                    res_ok_next  = 1'b1;
                    res_rel_next = CNT_W'(32'(count_next));
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {res_rel_reg, res_frame_reg, res_ok_reg};
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            p_reg         <= '0;
            run_reg       <= '0;
            count_reg     <= '0;
            found_reg     <= 1'b0;
            walk_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            p_reg         <= p_next;
            run_reg       <= run_next;
            count_reg     <= count_next;
            found_reg     <= found_next;
            walk_reg      <= walk_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        first_reg     <= first_next;
        last_reg      <= last_next;
        page_reg      <= page_next;
        want_reg      <= want_next;
        res_ok_reg    <= res_ok_next;
        res_frame_reg <= res_frame_next;
        res_rel_reg   <= res_rel_next;
        out_data_reg  <= out_data_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    a_onehot_state: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg))
        else $error("state not one-hot");

    a_mark_needs_find: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_MARK |-> found_reg)
        else $error("marking pass without a found run");

    a_walk_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WALK && p_reg == LAST) |=> state_reg == ST_DONE)
        else $error("walk pass did not end");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_WALK |-> 32'(count_reg) <= 32'(n_pages))
        else $error("released count beyond pool");

endmodule
